FILE: rtl/urr_pkg.sv
// ----------------------------------------------------------------------------
// urr_pkg: shared definitions for the uniform range reducer
// Field widths, register map and reset values used by the block's modules.
// ----------------------------------------------------------------------------
package urr_pkg;

	// Payload and configuration data width
	localparam int DATA_BITS = 64;

	// Default working width of the reduction
	localparam int WORD_BITS_DEF = 64;

	// APB address width: two 64-bit registers at byte addresses 0 and 8
	localparam int ADDR_BITS = 4;

	// Register select, taken from address bit 3
	localparam logic REG_MINIMUM = 1'b0;
	localparam logic REG_MAXIMUM = 1'b1;

	// Register reset values
	localparam logic [DATA_BITS-1:0] RANGE_MIN_RESET = 64'd0;
	localparam logic [DATA_BITS-1:0] RANGE_MAX_RESET = 64'd100;

endpackage

FILE: rtl/urr_ifs.sv
// ----------------------------------------------------------------------------
// urr_ifs: valid/ready channels of the uniform range reducer
// One channel carries raw random words in, the other carries ranged values out.
// ----------------------------------------------------------------------------
interface urr_word_if
	import urr_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink (input valid, input random_word, output ready);
endinterface

interface urr_value_if
	import urr_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] ranged_value;

	modport source (output valid, output ranged_value, input ready);
	modport sink (input valid, input ranged_value, output ready);
endinterface

FILE: rtl/urr_cell.sv
// ----------------------------------------------------------------------------
// urr_cell: one restoring-division step of the reduction chain
// Shifts one dividend bit into each of two running remainders (the random
// word and the all-ones word), subtracts the span where it fits, and hands
// the result to the next cell.
// ----------------------------------------------------------------------------
module urr_cell
	import urr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int BIT_POS   = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [WORD_BITS-1:0] span,
	input  logic                 up_vld,
	input  logic [WORD_BITS-1:0] up_word,
	input  logic [WORD_BITS-1:0] up_rw,
	input  logic [WORD_BITS-1:0] up_rm,
	output logic                 dn_vld,
	output logic [WORD_BITS-1:0] dn_word,
	output logic [WORD_BITS-1:0] dn_rw,
	output logic [WORD_BITS-1:0] dn_rm
);

	logic [WORD_BITS:0]   rw_sh;
	logic [WORD_BITS:0]   rm_sh;
	logic [WORD_BITS+1:0] rw_df;
	logic [WORD_BITS+1:0] rm_df;
	logic [WORD_BITS-1:0] rw_nx;
	logic [WORD_BITS-1:0] rm_nx;

	logic                 vld_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] rw_q;
	logic [WORD_BITS-1:0] rm_q;

	// Shift in the next dividend bit; the all-ones dividend always brings a one
	assign rw_sh = {up_rw, up_word[BIT_POS]};
	assign rm_sh = {up_rm, 1'b1};

	// Trial subtract; a borrow keeps the shifted remainder
	assign rw_df = {1'b0, rw_sh} - {2'b00, span};
	assign rm_df = {1'b0, rm_sh} - {2'b00, span};
	assign rw_nx = rw_df[WORD_BITS+1] ? rw_sh[WORD_BITS-1:0] : rw_df[WORD_BITS-1:0];
	assign rm_nx = rm_df[WORD_BITS+1] ? rm_sh[WORD_BITS-1:0] : rm_df[WORD_BITS-1:0];

	// Track transaction presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= up_vld;
		end
	end

	// Advance the remainders and the word
	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= up_word;
			rw_q   <= rw_nx;
			rm_q   <= rm_nx;
		end
	end

	assign dn_vld  = vld_q;
	assign dn_word = word_q;
	assign dn_rw   = rw_q;
	assign dn_rm   = rm_q;

endmodule

FILE: rtl/urr_cfg.sv
// ----------------------------------------------------------------------------
// urr_cfg: APB register file of the uniform range reducer
// Holds range minimum and maximum and keeps the span and rejection enable
// up to date on every write.
// ----------------------------------------------------------------------------
module urr_cfg
	import urr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output logic [WORD_BITS-1:0] lo,
	output logic [WORD_BITS-1:0] span,
	output logic                 rej_en
);

	localparam logic [WORD_BITS-1:0] SpanReset =
		WORD_BITS'(RANGE_MAX_RESET - RANGE_MIN_RESET + 64'd1);

	logic                 wr_en;
	logic                 reg_sel;
	logic [DATA_BITS-1:0] min_q;
	logic [DATA_BITS-1:0] max_q;
	logic [WORD_BITS-1:0] span_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3];

	// Write registers and refresh the span in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= RANGE_MIN_RESET;
			max_q  <= RANGE_MAX_RESET;
			span_q <= SpanReset;
		end else if (wr_en) begin
			case (reg_sel)
				REG_MINIMUM: begin
					min_q  <= pwdata;
					span_q <= max_q[WORD_BITS-1:0] - pwdata[WORD_BITS-1:0] + WORD_BITS'(1);
				end
				REG_MAXIMUM: begin
					max_q  <= pwdata;
					span_q <= pwdata[WORD_BITS-1:0] - min_q[WORD_BITS-1:0] + WORD_BITS'(1);
				end
				default: begin
					span_q <= span_q;
				end
			endcase
		end
	end

	// Return register contents
	always_comb begin
		case (reg_sel)
			REG_MINIMUM: prdata = min_q;
			REG_MAXIMUM: prdata = max_q;
			default:     prdata = '0;
		endcase
	end

	assign lo     = min_q[WORD_BITS-1:0];
	assign span   = span_q;
	// Reject only for spans that are neither zero nor a power of two
	assign rej_en = |(span_q & (span_q - WORD_BITS'(1)));

endmodule

FILE: rtl/uniform_range_reducer.sv
// ----------------------------------------------------------------------------
// uniform_range_reducer: maps raw random words uniformly onto a range
// Random words enter on in_ch; each accepted word is reduced modulo the span
// (maximum - minimum + 1) and offset by the minimum, then leaves on out_ch.
// For spans that are not a power of two, words above the rejection limit
// are dropped and produce no output transaction.
// The reduction runs through a chain of WORD_BITS division cells, one
// dividend bit per cell, followed by one output register: the first cell
// loads at the accepting edge, and each result passes through every cell
// register and then the output register before it leaves on out_ch.
// One word is taken per cycle while out_ch does not stall; the chain of cells
// sets that figure, each cell holding one transaction in flight.
// When out_ch stalls with a result waiting, the whole chain holds and
// in_ch.ready goes low until the result is taken.
// Reset empties the chain and the output register, and sets minimum to 0
// and maximum to 100. Range registers sit on the APB port at byte
// addresses 0 and 8; write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module uniform_range_reducer
	import urr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	urr_word_if.sink             in_ch,
	urr_value_if.source          out_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	logic [WORD_BITS-1:0] lo;
	logic [WORD_BITS-1:0] span;
	logic                 rej_en;
	logic                 en;

	logic                 vld_c  [0:WORD_BITS];
	logic [WORD_BITS-1:0] word_c [0:WORD_BITS];
	logic [WORD_BITS-1:0] rw_c   [0:WORD_BITS];
	logic [WORD_BITS-1:0] rm_c   [0:WORD_BITS];

	logic [WORD_BITS:0]   tail_sum;
	logic                 reject;
	logic [WORD_BITS-1:0] result;

	logic                 out_vld_q;
	logic [DATA_BITS-1:0] out_val_q;

	// Configuration registers
	urr_cfg #(
		.WORD_BITS(WORD_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.lo      (lo),
		.span    (span),
		.rej_en  (rej_en)
	);

	// Hold the chain while a result waits at the output
	assign en          = ~out_vld_q | out_ch.ready;
	assign in_ch.ready = en;

	// Feed the first cell with empty remainders
	assign vld_c[0]  = in_ch.valid;
	assign word_c[0] = in_ch.random_word[WORD_BITS-1:0];
	assign rw_c[0]   = '0;
	assign rm_c[0]   = '0;

	// Division chain, most significant bit first
	for (genvar k = 0; k < WORD_BITS; k++) begin : g_cell
		urr_cell #(
			.WORD_BITS(WORD_BITS),
			.BIT_POS  (WORD_BITS - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.span    (span),
			.up_vld  (vld_c[k]),
			.up_word (word_c[k]),
			.up_rw   (rw_c[k]),
			.up_rm   (rm_c[k]),
			.dn_vld  (vld_c[k+1]),
			.dn_word (word_c[k+1]),
			.dn_rw   (rw_c[k+1]),
			.dn_rm   (rm_c[k+1])
		);
	end

	// Drop words above the limit: word > all-ones - rem - 1 means word + rem >= all-ones
	assign tail_sum = {1'b0, word_c[WORD_BITS]} + {1'b0, rm_c[WORD_BITS]};
	assign reject   = rej_en & (tail_sum >= {1'b0, {WORD_BITS{1'b1}}});
	assign result   = rw_c[WORD_BITS] + lo;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_c[WORD_BITS] & ~reject;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (en) begin
			out_val_q <= DATA_BITS'(result);
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.ranged_value = out_val_q;

endmodule

FILE: verif/tb_uniform_range_reducer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uniform_range_reducer: self-checking bench for the uniform range reducer
// Streams random words through the block under a series of range settings
// and handshake pacing modes. Each accepted word is reduced by an in-bench
// predictor, which either queues the expected ranged value or drops the word
// as rejected. Each output transaction is checked against the oldest queued
// value.
// ----------------------------------------------------------------------------
module tb_uniform_range_reducer;
	import urr_pkg::*;

	localparam logic [DATA_BITS-1:0] ALL_ONES = '1;
	localparam int NUM_PHASES      = 14;
	localparam int ITEMS_PER_PHASE = 95;
	// Pipeline depth plus margin; also covers words still in flight that get dropped
	localparam int SETTLE_CYCLES   = 80;
	localparam int CYCLE_LIMIT     = 200000;

	typedef enum logic [1:0] {
		PACE_STEADY,
		PACE_SLOW_SOURCE,
		PACE_SLOW_SINK,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] lo;
		logic [DATA_BITS-1:0] hi;
	} range_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	urr_word_if  word_ch ();
	urr_value_if value_ch ();

	uniform_range_reducer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (word_ch),
		.out_ch  (value_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Bench copy of the range registers
	range_t cur_range = '{lo: RANGE_MIN_RESET, hi: RANGE_MAX_RESET};

	logic [DATA_BITS-1:0] pending_words[$];
	logic [DATA_BITS-1:0] expected_values[$];
	int                   source_idle_pct = 0;
	int                   sink_stall_pct = 0;
	int                   fail_count = 0;
	int                   cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Largest word kept for the range; all-ones when nothing is rejected
	function automatic logic [DATA_BITS-1:0] reject_limit(input range_t r);
		logic [DATA_BITS-1:0] span;
		span = r.hi - r.lo + 1'b1;
		if (r.lo == r.hi || span == '0 || (span & (span - 1'b1)) == '0)
			return ALL_ONES;
		return ALL_ONES - (ALL_ONES % span) - 1'b1;
	endfunction

	// Reduce one word into the range; returns 0 when the word is rejected
	function automatic bit reduce_word(input range_t r, input logic [DATA_BITS-1:0] w,
		output logic [DATA_BITS-1:0] value);
		logic [DATA_BITS-1:0] span;
		span = r.hi - r.lo + 1'b1;
		value = '0;
		if (r.lo == r.hi) begin
			value = r.lo;
			return 1'b1;
		end
		if (span == '0) begin
			value = w + r.lo;
			return 1'b1;
		end
		if (w > reject_limit(r))
			return 1'b0;
		value = (w % span) + r.lo;
		return 1'b1;
	endfunction

	// Random word, biased toward the rejection boundary and the extremes
	function automatic logic [DATA_BITS-1:0] pick_word(input range_t r);
		logic [DATA_BITS-1:0] limit;
		int                   roll;
		limit = reject_limit(r);
		roll = int'($urandom_range(99));
		if (roll < 15 && limit != ALL_ONES)
			return limit + DATA_BITS'($urandom_range(2)) - 64'd1;
		if (roll < 25) begin
			case ($urandom_range(4))
				0: return '0;
				1: return ALL_ONES;
				2: return 64'd1;
				3: return ALL_ONES - 1'b1;
				default: return 64'h8000_0000_0000_0000;
			endcase
		end
		if (roll < 35)
			return DATA_BITS'($urandom_range(300));
		return {$urandom, $urandom};
	endfunction

	// Write one range register over APB: setup cycle, then access cycle
	task automatic write_reg(input logic sel, input logic [DATA_BITS-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Word driver: predict on each accepted transaction, then offer the next word
	always @(posedge clk or negedge arst_n) begin : word_driver
		logic [DATA_BITS-1:0] value;
		bit                   kept;
		if (!arst_n) begin
			word_ch.valid <= 1'b0;
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				kept = reduce_word(cur_range, word_ch.random_word, value);
				if (kept)
					expected_values.push_back(value);
			end
			if (!word_ch.valid || word_ch.ready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= source_idle_pct) begin
					word_ch.valid       <= 1'b1;
					word_ch.random_word <= pending_words.pop_front();
				end else begin
					word_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Value monitor: check each output transaction, stall at random
	always @(posedge clk or negedge arst_n) begin : value_monitor
		logic [DATA_BITS-1:0] want;
		if (!arst_n) begin
			value_ch.ready <= 1'b0;
		end else begin
			if (value_ch.valid && value_ch.ready) begin
				if (expected_values.size() == 0) begin
					$display("%0t: unexpected ranged_value, expected none, actual %h",
						$time, value_ch.ranged_value);
					fail_count++;
				end else begin
					want = expected_values.pop_front();
					if (value_ch.ranged_value !== want) begin
						$display("%0t: ranged_value mismatch, expected %h, actual %h",
							$time, want, value_ch.ranged_value);
						fail_count++;
					end
				end
			end
			value_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("uniform_range_reducer regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		range_t r;
		pace_t  pace;
		word_ch.valid       = 1'b0;
		word_ch.random_word = '0;
		value_ch.ready      = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Pick the range for this phase; the first one keeps reset values
			r = cur_range;
			case (p)
				1: r = '{lo: '0, hi: ALL_ONES};
				2: r = '{lo: 64'd42, hi: 64'd42};
				3: r = '{lo: '0, hi: '0};
				4: r = '{lo: ALL_ONES, hi: ALL_ONES};
				5: r = '{lo: '0, hi: 64'h8000_0000_0000_0000};
				6: r = '{lo: ALL_ONES - 64'd5, hi: 64'd10};
				7: r = '{lo: 64'd1000, hi: 64'd1000 + 64'hFFFF_FFFF};
				8: r = '{lo: 64'd5, hi: 64'd4};
				9: r = '{lo: '0, hi: ALL_ONES - 1'b1};
				10: r = '{lo: '0, hi: 64'd1};
				11: begin
					r.lo = {$urandom, $urandom};
					r.hi = r.lo + DATA_BITS'($urandom_range(65535));
				end
				12: r = '{lo: 64'd123, hi: 64'd123 + 64'h8000_0000_0000_0000};
				13: r = '{lo: {$urandom, $urandom}, hi: {$urandom, $urandom}};
				default: ;
			endcase
			if (p > 0) begin
				write_reg(REG_MINIMUM, r.lo);
				write_reg(REG_MAXIMUM, r.hi);
				cur_range = r;
			end

			pace = pace_t'(p % 4);
			case (pace)
				PACE_STEADY: begin
					source_idle_pct = 0;
					sink_stall_pct  = 0;
				end
				PACE_SLOW_SOURCE: begin
					source_idle_pct = 86;
					sink_stall_pct  = 0;
				end
				PACE_SLOW_SINK: begin
					source_idle_pct = 0;
					sink_stall_pct  = 86;
				end
				default: begin
					source_idle_pct = 28;
					sink_stall_pct  = 28;
				end
			endcase

			// Directed words at the reset range: extremes, span edges, bit patterns
			if (p == 0) begin
				pending_words.push_back('0);
				pending_words.push_back(ALL_ONES);
				pending_words.push_back(64'd1);
				pending_words.push_back(64'd100);
				pending_words.push_back(64'd101);
				pending_words.push_back(64'h8000_0000_0000_0000);
				pending_words.push_back(64'h5555_5555_5555_5555);
				pending_words.push_back(64'hAAAA_AAAA_AAAA_AAAA);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				pending_words.push_back(pick_word(cur_range));

			// Drain: every word taken, every result seen, then let the chain empty
			do
				@(negedge clk);
			while (pending_words.size() > 0 || word_ch.valid || expected_values.size() > 0);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end

		if (fail_count == 0)
			$display("uniform_range_reducer regression: pass");
		else
			$display("uniform_range_reducer regression: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/urr_pkg.sv
rtl/urr_ifs.sv
rtl/urr_cell.sv
rtl/urr_cfg.sv
rtl/uniform_range_reducer.sv
verif/tb_uniform_range_reducer.sv
